// ----- rtl/nfpa_pkg.sv -----
// Shared types and constants of the next-fit page run allocator.
package nfpa_pkg;

	// Widths fixed by the request and result formats.
	localparam int unsigned ADDR_W  = 48;
	localparam int unsigned ENTRY_W = 13;

	// Request kinds.
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	// Configuration register indexes.
	localparam logic REG_BASE  = 1'b0;
	localparam logic REG_PAGES = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [ENTRY_W-1:0] page_count;
		logic [ADDR_W-1:0]  free_address;
	} nfpa_req_t;

	typedef struct packed {
		logic              success;
		logic [ADDR_W-1:0] page_address;
	} nfpa_rsp_t;

endpackage

// ----- rtl/next_fit_page_run_allocator.sv -----
// Top level of the next-fit page run allocator: request sequencer around the run table.
//
// Usage. A request is taken at a rising edge where start is high and busy is low. An
// allocate request (kind 0) asks for page_count consecutive pages; a free request
// (kind 1) releases the run whose head page sits at free_address. Every request
// produces exactly one result: done is high for one cycle with rsp valid, and the
// receiver cannot hold it off. busy stays high from acceptance to the cycle before
// done, so a new request may be presented while done is shown. A rejected allocate
// never raises busy.
// Sequence. A free is checked and written in ST_FREE; an allocate rejected for a zero or
// oversized count is answered at once. Any other allocate scans the run table one read
// at a time from the scan start to the pool end, then wraps to the pool start; a free
// head that is not taken at once is fit-checked page by page. A scan reads at most
// about twice the pool.
// Configuration. base_address and pages_in_use are written through cfg_we, cfg_index and
// cfg_data, by the user only while no request is in progress; the block does not enforce it.
// Reset. After arst_n is released the block clears the run table, one entry per
// cycle; busy is high meanwhile. Configuration writes are taken during that time.
module next_fit_page_run_allocator #(
	parameter int unsigned TABLE_PAGES = 4096,
	parameter int unsigned PAGE_SHIFT  = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  nfpa_pkg::nfpa_req_t        req,
	output logic                       done,
	output nfpa_pkg::nfpa_rsp_t        rsp,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [nfpa_pkg::ADDR_W-1:0] cfg_data
);
	import nfpa_pkg::*;

	localparam int unsigned AW = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
	// Scan indexes can run past the pool by up to one run length.
	localparam int unsigned IW = $clog2(TABLE_PAGES + (1 << ENTRY_W)) + 1;
	localparam int unsigned FW = ADDR_W - PAGE_SHIFT;

	typedef enum logic [6:0] {
		ST_CLEAR    = 7'b0000001,
		ST_IDLE     = 7'b0000010,
		ST_FREE     = 7'b0000100,
		ST_SCAN     = 7'b0001000,
		ST_SCAN_CHK = 7'b0010000,
		ST_FIT      = 7'b0100000,
		ST_FIT_CHK  = 7'b1000000
	} state_t;

	state_t             state_q, state_d;
	logic [IW-1:0]      i_q, i_d;
	logic [IW-1:0]      j_q, j_d;
	logic [ENTRY_W-1:0] n_q, n_d;
	logic               wrap_q, wrap_d;
	logic               first_pass_q, first_pass_d;
	logic [ENTRY_W-1:0] scan_start_q, scan_start_d;
	logic [ADDR_W-1:0]  base_q;
	logic [ENTRY_W-1:0] pages_q;
	logic [ADDR_W-1:0]  free_addr_q, free_addr_d;
	logic               done_q, done_d;
	nfpa_rsp_t          rsp_q, rsp_d;

	logic               tbl_we;
	logic [AW-1:0]      tbl_waddr;
	logic [ENTRY_W-1:0] tbl_wdata;
	logic               tbl_re;
	logic [AW-1:0]      tbl_raddr;
	logic [ENTRY_W-1:0] tbl_rdata;
	logic               tbl_ready;

	logic [IW-1:0]      total;
	logic [IW-1:0]      start_ext;
	logic [IW-1:0]      lim;
	logic [IW-1:0]      bound;
	logic [IW-1:0]      rd_ext;
	logic [IW-1:0]      run_end;
	logic [ADDR_W:0]    free_diff;
	logic [FW-1:0]      free_idx;
	logic               free_ok;

	nfpa_table #(
		.DEPTH(TABLE_PAGES),
		.AW   (AW)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata),
		.ready (tbl_ready)
	);

	// Pool size and scan bounds.
	assign total     = (IW'(pages_q) > IW'(TABLE_PAGES)) ? IW'(TABLE_PAGES) : IW'(pages_q);
	assign start_ext = IW'(scan_start_q);
	assign lim       = (start_ext < total) ? start_ext : total;
	assign bound     = wrap_q ? lim : total;
	assign rd_ext    = IW'(tbl_rdata);
	assign run_end   = i_q + IW'(n_q);

	// Free address check: aligned, not below the base, and inside the pool.
	assign free_diff = {1'b0, free_addr_q} - {1'b0, base_q};
	assign free_idx  = free_diff[ADDR_W-1:PAGE_SHIFT];
	assign free_ok   = (free_addr_q[PAGE_SHIFT-1:0] == '0) && !free_diff[ADDR_W]
		&& (free_idx < FW'(total));

	// Request sequencer: one table read per step, decision on the registered data.
	always_comb begin
		state_d      = state_q;
		i_d          = i_q;
		j_d          = j_q;
		n_d          = n_q;
		wrap_d       = wrap_q;
		first_pass_d = first_pass_q;
		scan_start_d = scan_start_q;
		free_addr_d  = free_addr_q;
		done_d       = 1'b0;
		rsp_d        = rsp_q;
		tbl_we       = 1'b0;
		tbl_waddr    = i_q[AW-1:0];
		tbl_wdata    = n_q;
		tbl_re       = 1'b0;
		tbl_raddr    = i_q[AW-1:0];

		case (state_q)
			ST_CLEAR: begin
				if (tbl_ready) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (req.kind == KIND_FREE) begin
						free_addr_d = req.free_address;
						state_d     = ST_FREE;
					end else if (req.page_count == '0 || IW'(req.page_count) > total) begin
						// Zero or oversized count is rejected at once.
						done_d = 1'b1;
						rsp_d  = '0;
					end else begin
						n_d     = req.page_count;
						i_d     = start_ext;
						wrap_d  = 1'b0;
						state_d = ST_SCAN;
					end
				end
			end
			ST_FREE: begin
				if (free_ok) begin
					tbl_we    = 1'b1;
					tbl_waddr = free_idx[AW-1:0];
					tbl_wdata = '0;
				end
				rsp_d.success      = free_ok;
				rsp_d.page_address = '0;
				done_d             = 1'b1;
				state_d            = ST_IDLE;
			end
			ST_SCAN: begin
				if (i_q >= bound) begin
					if (wrap_q) begin
						done_d  = 1'b1;
						rsp_d   = '0;
						state_d = ST_IDLE;
					end else begin
						// End of the forward scan; multi-page requests leave first-pass mode.
						if (n_q != ENTRY_W'(1)) begin
							first_pass_d = 1'b0;
						end
						wrap_d = 1'b1;
						i_d    = '0;
					end
				end else begin
					tbl_re    = 1'b1;
					tbl_raddr = i_q[AW-1:0];
					state_d   = ST_SCAN_CHK;
				end
			end
			ST_SCAN_CHK: begin
				if (tbl_rdata != '0) begin
					i_d     = i_q + rd_ext;
					state_d = ST_SCAN;
				end else if (n_q == ENTRY_W'(1) || (first_pass_q && run_end < total)) begin
					tbl_we             = 1'b1;
					scan_start_d       = run_end[ENTRY_W-1:0];
					rsp_d.success      = 1'b1;
					rsp_d.page_address = base_q + (ADDR_W'(i_q) << PAGE_SHIFT);
					done_d             = 1'b1;
					state_d            = ST_IDLE;
				end else if (first_pass_q) begin
					// Head too close to the pool end: first-pass mode ends, scan wraps.
					first_pass_d = 1'b0;
					wrap_d       = 1'b1;
					i_d          = '0;
					state_d      = ST_SCAN;
				end else begin
					j_d     = i_q + IW'(1);
					state_d = ST_FIT;
				end
			end
			ST_FIT: begin
				if (j_q >= run_end) begin
					tbl_we             = 1'b1;
					scan_start_d       = run_end[ENTRY_W-1:0];
					rsp_d.success      = 1'b1;
					rsp_d.page_address = base_q + (ADDR_W'(i_q) << PAGE_SHIFT);
					done_d             = 1'b1;
					state_d            = ST_IDLE;
				end else if (j_q >= total) begin
					i_d     = j_q;
					state_d = ST_SCAN;
				end else begin
					tbl_re    = 1'b1;
					tbl_raddr = j_q[AW-1:0];
					state_d   = ST_FIT_CHK;
				end
			end
			ST_FIT_CHK: begin
				if (tbl_rdata != '0) begin
					i_d     = j_q + rd_ext;
					state_d = ST_SCAN;
				end else begin
					j_d     = j_q + IW'(1);
					state_d = ST_FIT;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			first_pass_q <= 1'b1;
			scan_start_q <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q      <= state_d;
			first_pass_q <= first_pass_d;
			scan_start_q <= scan_start_d;
			done_q       <= done_d;
		end
	end

	// Scan working registers and result payload.
	always_ff @(posedge clk) begin
		i_q         <= i_d;
		j_q         <= j_d;
		n_q         <= n_d;
		wrap_q      <= wrap_d;
		free_addr_q <= free_addr_d;
		rsp_q       <= rsp_d;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			pages_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE:  base_q  <= cfg_data;
				REG_PAGES: pages_q <= cfg_data[ENTRY_W-1:0];
				default:   base_q  <= base_q;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// A result only follows a taken request or a cycle of work.
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q != ST_CLEAR && (start || busy)))
		else $error("result strobe without a request in progress");

	// Failures and frees never carry an address.
	a_fail_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.success) |-> (rsp.page_address == '0))
		else $error("failed result carries a nonzero address");

	// Scan reads stay inside the pool.
	a_scan_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_CHK) |-> (i_q < total))
		else $error("scan read outside the pool");

	// Fit-check reads lie after the candidate head and inside the pool.
	a_fit_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIT_CHK) |-> (j_q < total && j_q > i_q))
		else $error("fit check read out of order or outside the pool");

	// First-pass mode, once left, never comes back.
	a_first_pass_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!first_pass_q |=> !first_pass_q)
		else $error("first-pass mode re-entered");

endmodule

// ----- rtl/nfpa_table.sv -----
// Run table memory with a registered read port and a clearing sweep after reset.
module nfpa_table #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [nfpa_pkg::ENTRY_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [nfpa_pkg::ENTRY_W-1:0] rdata,
	output logic                        ready
);
	import nfpa_pkg::*;

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic               clr_busy_q;
	logic [AW-1:0]      clr_addr_q;
	logic [ENTRY_W-1:0] rdata_q;

	// The sweep walks every entry once, writing zero, then hands the port over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Single write port shared by the sweep and the allocator.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
	assign ready = !clr_busy_q;

endmodule
